[rtl/core/sccenc_pkg.sv]
// Shared types and constants for the size-class coefficient encoder.
// No dependencies; imported by size_class_coefficient_encoder_core.
`timescale 1ns / 1ps

package sccenc_pkg;

	// Sequencer states, one-hot
	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_DIV  = 6'b000010,
		ST_LOAD = 6'b000100,
		ST_HDR  = 6'b001000,
		ST_CODE = 6'b010000,
		ST_PAD  = 6'b100000
	} state_t;

	// Configuration register indexes
	localparam logic REG_MODULUS = 1'b0;
	localparam logic REG_VLEN    = 1'b1;

	// Register reset values
	localparam logic [15:0] MODULUS_RST = 16'd65535;
	localparam logic [15:0] VLEN_RST    = 16'd256;

	// Stream framing
	localparam int          SREG_W   = 40;
	localparam logic [5:0]  HDR_BITS = 6'd40;
	localparam logic [3:0]  MAX_WORDS = 4'd8;

	// Size-class limits and offsets
	localparam logic [15:0] CLS0_MAX = 16'd3;
	localparam logic [15:0] CLS1_MAX = 16'd15;
	localparam logic [15:0] CLS2_MAX = 16'd255;
	localparam logic [15:0] CLS1_OFF = 16'd4;
	localparam logic [15:0] CLS2_OFF = 16'd16;
	localparam logic [15:0] CLS3_OFF = 16'd256;

	localparam logic [1:0]  CLS0 = 2'd0;
	localparam logic [1:0]  CLS1 = 2'd1;
	localparam logic [1:0]  CLS2 = 2'd2;
	localparam logic [1:0]  CLS3 = 2'd3;

endpackage

[rtl/core/size_class_coefficient_encoder_core.sv]
// Size-class coefficient encoder: serial modulo, prefix coding and MSB-first byte packing.
// Depends on sccenc_pkg.
// Sequence: accept, bit-serial division, load, a 40-bit header (first coefficient of a vector only),
//   4 to 18 code bits at one bit per cycle unless the output stalls, and a pad step at vector end.
// A new coefficient is not taken until the current one is fully packed; the bit-serial divider
//   and the one-bit-per-cycle packer set the pace, which slows while the output stalls.
// Reset: asynchronous, active low; modulus 65535, vector length 256, packer empty.
`timescale 1ns / 1ps

module size_class_coefficient_encoder_core
	import sccenc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_wdata,
	// coefficient input
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] coefficient,
	// byte output
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_byte,
	output logic        last
);

	state_t             state_q;
	logic [15:0]        modulus_q;
	logic [15:0]        vlen_q;
	logic [15:0]        seen_q;
	logic [15:0]        dvd_q;
	logic [15:0]        rem_q;
	logic [3:0]         div_cnt_q;
	logic [4:0]         w_q;
	logic [SREG_W-1:0]  sreg_q;
	logic [5:0]         bits_left_q;
	logic [6:0]         acc_q;
	logic [2:0]         pcnt_q;
	logic [3:0]         words_q;
	logic               out_valid_q;
	logic [7:0]         out_byte_q;
	logic               last_q;

	logic [15:0]        m1;
	logic [16:0]        div_r;
	logic               div_ge;
	logic [17:0]        code;
	logic [5:0]         code_n;
	logic [15:0]        off3;
	logic               is_end;
	logic               take;
	logic               step_en;
	logic               shifting;
	logic               emit;
	logic               cur_bit;
	logic               final_bit;
	logic [7:0]         pad_byte;

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign last      = last_q;

	// divider step and class-3 width scan
	assign m1     = modulus_q - 16'd1;
	assign div_r  = {rem_q, dvd_q[15]};
	assign div_ge = (div_r >= {1'b0, modulus_q});

	// size class and offset, left-aligned in an 18-bit code word
	always_comb begin
		off3   = rem_q - CLS3_OFF;
		code   = '0;
		code_n = 6'd4;
		if (rem_q <= CLS0_MAX) begin
			code   = {CLS0, rem_q[1:0], 14'd0};
			code_n = 6'd4;
		end else if (rem_q <= CLS1_MAX) begin
			code   = {CLS1, 4'(rem_q - CLS1_OFF), 12'd0};
			code_n = 6'd6;
		end else if (rem_q <= CLS2_MAX) begin
			code   = {CLS2, 8'(rem_q - CLS2_OFF), 8'd0};
			code_n = 6'd10;
		end else begin
			code   = {CLS3, 16'(off3 << (5'd16 - w_q))};
			code_n = 6'(w_q) + 6'd2;
		end
	end

	// packer handshake terms
	assign is_end    = ((seen_q + 16'd1) == vlen_q);
	assign take      = out_valid_q && !out_stall;
	assign step_en   = !((pcnt_q == 3'd7) && out_valid_q && out_stall);
	assign shifting  = (state_q == ST_HDR) || (state_q == ST_CODE);
	assign cur_bit   = sreg_q[SREG_W-1];
	assign final_bit = (state_q == ST_CODE) && (bits_left_q == 6'd1);
	assign pad_byte  = 8'({acc_q, 1'b0} << (3'd7 - pcnt_q));

	// a word enters the output register: full byte from the packer or the padded tail
	assign emit = (shifting && step_en && (pcnt_q == 3'd7)) ||
		((state_q == ST_PAD) && (pcnt_q != 3'd0) && (words_q != MAX_WORDS) &&
		(!out_valid_q || !out_stall));

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= MODULUS_RST;
			vlen_q    <= VLEN_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MODULUS: modulus_q <= cfg_wdata;
				REG_VLEN:    vlen_q    <= cfg_wdata;
				default:     ;
			endcase
		end
	end

	// sequencer, divider, packer and output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			seen_q      <= '0;
			dvd_q       <= '0;
			rem_q       <= '0;
			w_q         <= '0;
			sreg_q      <= '0;
			acc_q       <= '0;
			pcnt_q      <= '0;
			words_q     <= '0;
			out_valid_q <= 1'b0;
			out_byte_q  <= '0;
			last_q      <= 1'b0;
			div_cnt_q   <= '0;
			bits_left_q <= '0;
		end else begin
			if (emit)
				out_valid_q <= 1'b1;
			else if (take)
				out_valid_q <= 1'b0;

			unique case (state_q) inside
				ST_IDLE: begin
					if (in_valid) begin
						dvd_q     <= coefficient;
						rem_q     <= '0;
						w_q       <= '0;
						div_cnt_q <= '0;
						words_q   <= '0;
						state_q   <= ST_DIV;
					end
				end

				ST_DIV: begin
					rem_q     <= div_ge ? 16'(div_r - {1'b0, modulus_q}) : div_r[15:0];
					dvd_q     <= {dvd_q[14:0], 1'b0};
					if (m1[div_cnt_q])
						w_q <= 5'(div_cnt_q) + 5'd1;
					div_cnt_q <= div_cnt_q + 4'd1;
					if (div_cnt_q == 4'd15)
						state_q <= ST_LOAD;
				end

				ST_LOAD: begin
					if (seen_q == 16'd0) begin
						sreg_q      <= {vlen_q, modulus_q, 3'd0, w_q};
						bits_left_q <= HDR_BITS;
						state_q     <= ST_HDR;
					end else begin
						sreg_q      <= {code, 22'd0};
						bits_left_q <= code_n;
						state_q     <= ST_CODE;
					end
				end

				ST_HDR, ST_CODE: begin
					if (step_en) begin
						// one bit into the packer
						if (pcnt_q == 3'd7) begin
							out_byte_q  <= {acc_q, cur_bit};
							last_q      <= final_bit && is_end;
							words_q     <= words_q + 4'd1;
							acc_q       <= '0;
							pcnt_q      <= '0;
						end else begin
							acc_q  <= {acc_q[5:0], cur_bit};
							pcnt_q <= pcnt_q + 3'd1;
						end
						if ((bits_left_q == 6'd1) && (state_q == ST_HDR)) begin
							// header done, code word follows
							sreg_q      <= {code, 22'd0};
							bits_left_q <= code_n;
							state_q     <= ST_CODE;
						end else begin
							sreg_q      <= {sreg_q[SREG_W-2:0], 1'b0};
							bits_left_q <= bits_left_q - 6'd1;
							if (bits_left_q == 6'd1) begin
								if (is_end) begin
									seen_q  <= '0;
									state_q <= ST_PAD;
								end else begin
									seen_q  <= seen_q + 16'd1;
									state_q <= ST_IDLE;
								end
							end
						end
					end
				end

				ST_PAD: begin
					// flush a partial word, if any, with zero fill, marked last, unless MAX_WORDS words were sent
					if (pcnt_q != 3'd0 && words_q != MAX_WORDS) begin
						if (!out_valid_q || !out_stall) begin
							out_byte_q  <= pad_byte;
							last_q      <= 1'b1;
							acc_q       <= '0;
							pcnt_q      <= '0;
							state_q     <= ST_IDLE;
						end
					end else begin
						acc_q   <= '0;
						pcnt_q  <= '0;
						state_q <= ST_IDLE;
					end
				end

				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
